// ===== sv/iff_pkg.sv =====
// Shared types, codes and character constants of the integer field formatter.
package iff_pkg;

    // Default saturation limit of the field width.
    localparam int DEF_MAX_WIDTH = 60;

    // Digit register size: enough BCD digits for any 64-bit magnitude.
    localparam int NUM_DEC_DIGITS = 20;
    localparam int NUM_HEX_DIGITS = 16;
    localparam int DIGIT_BITS     = 4 * NUM_DEC_DIGITS;

    // Conversion codes.
    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEXL = 2'd2;
    localparam logic [1:0] OP_HEXU = 2'd3;

    // Argument size codes.
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    // ASCII characters.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_PFX0,
        S_PFX1,
        S_LPAD,
        S_SIGN,
        S_DIG,
        S_RPAD
    } t_state;

    // Maps one digit value to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (nib < 4'd10) begin
            return CH_ZERO + {4'b0, nib};
        end
        return base + {4'b0, nib} - 8'd10;
    endfunction

endpackage

// ===== sv/integer_field_formatter.sv =====
// Integer field formatter: decimal or hex conversion of one request into padded ASCII text.
// Decimal requests first run through the bit-serial BCD converter, then strip leading zero
// digits; hex requests only strip leading zero digits.
// Throughput: one character per cycle afterwards while the output is not stalled; a new request
// is taken only once the block is back in idle after the last character of the previous one.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module integer_field_formatter #(
    parameter int MAX_WIDTH = iff_pkg::DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_arg_size,
    input  logic        i_show_sign,
    input  logic        i_alt_prefix,
    input  logic        i_left_justify,
    input  logic        i_zero_pad,
    input  logic [5:0]  i_field_width,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_char,
    output logic        o_last
);
    import iff_pkg::*;

    localparam logic [5:0] WIDTH_LIMIT = 6'(MAX_WIDTH);

    t_state r_state, n_state;

    logic [DIGIT_BITS-1:0] r_digits;
    logic [63:0]           r_mag;
    logic [5:0]            r_bit;
    logic [4:0]            r_ndig;
    logic [5:0]            r_pad;
    logic [5:0]            r_width;
    logic                  r_upper, r_neg, r_sign, r_pfx, r_lj, r_zp;

    logic                  r_out_valid;
    logic [7:0]            r_out_char;
    logic                  r_last;

    logic                  w_accept;
    logic [63:0]           w_ext, w_mag;
    logic                  w_neg, w_hex;
    logic [DIGIT_BITS-1:0] w_adj;
    logic [5:0]            w_tlen, w_pad;
    logic                  w_pad_nz, w_has_lpad, w_has_rpad, w_norm_done;
    logic                  w_load;
    logic [7:0]            w_char;
    logic                  w_last;
    logic                  w_bcd_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_last;

    // Cut the argument to its size, sign-extend for signed decimal, take the magnitude.
    always_comb begin
        case (i_arg_size)
            SZ_8: begin
                w_ext = (i_op == OP_SDEC) ? {{56{i_value[7]}}, i_value[7:0]}
                                          : {56'b0, i_value[7:0]};
            end
            SZ_16: begin
                w_ext = (i_op == OP_SDEC) ? {{48{i_value[15]}}, i_value[15:0]}
                                          : {48'b0, i_value[15:0]};
            end
            SZ_32: begin
                w_ext = (i_op == OP_SDEC) ? {{32{i_value[31]}}, i_value[31:0]}
                                          : {32'b0, i_value[31:0]};
            end
            default: begin
                w_ext = i_value;
            end
        endcase
        w_hex = i_op[1];
        w_neg = (i_op == OP_SDEC) && w_ext[63];
        w_mag = w_neg ? (64'd0 - w_ext) : w_ext;
    end

    // Double-dabble correction: every BCD digit of five or more gets three added.
    always_comb begin
        w_bcd_ok = 1'b1;
        for (int k = 0; k < NUM_DEC_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_digits[4*k +: 4] >= 4'd5) ? r_digits[4*k +: 4] + 4'd3
                                                           : r_digits[4*k +: 4];
            if (r_digits[4*k +: 4] > 4'd9) begin
                w_bcd_ok = 1'b0;
            end
        end
    end

    // Text length, padding count and the phases that this request needs.
    always_comb begin
        w_tlen      = {1'b0, r_ndig} + {5'b0, r_sign};
        w_pad       = (r_width > w_tlen) ? (r_width - w_tlen) : 6'd0;
        w_pad_nz    = (r_state == S_NORM) ? (w_pad != 6'd0) : (r_pad != 6'd0);
        w_has_lpad  = !r_lj && w_pad_nz;
        w_has_rpad  = r_lj && w_pad_nz;
        w_norm_done = (r_digits[DIGIT_BITS-1 -: 4] != 4'd0) || (r_ndig == 5'd1);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_hex ? S_NORM : S_CONV;
                end
            end
            S_CONV: begin
                if (&r_bit) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (w_norm_done) begin
                    if (r_pfx) begin
                        n_state = S_PFX0;
                    end else if (w_has_lpad) begin
                        n_state = S_LPAD;
                    end else if (r_sign) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIG;
                    end
                end
            end
            S_PFX0: begin
                if (w_load) begin
                    n_state = S_PFX1;
                end
            end
            S_PFX1: begin
                if (w_load) begin
                    if (w_has_lpad) begin
                        n_state = S_LPAD;
                    end else if (r_sign) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIG;
                    end
                end
            end
            S_LPAD: begin
                if (w_load && (r_pad == 6'd1)) begin
                    n_state = r_sign ? S_SIGN : S_DIG;
                end
            end
            S_SIGN: begin
                if (w_load) begin
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (w_load && (r_ndig == 5'd1)) begin
                    n_state = w_has_rpad ? S_RPAD : S_IDLE;
                end
            end
            S_RPAD: begin
                if (w_load && (r_pad == 6'd1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Character of the current phase, and whether the output register can take it.
    always_comb begin
        w_load = 1'b0;
        w_char = CH_SPACE;
        w_last = 1'b0;
        case (r_state)
            S_PFX0: begin
                w_load = !r_out_valid || i_out_ready;
                w_char = CH_ZERO;
            end
            S_PFX1: begin
                w_load = !r_out_valid || i_out_ready;
                w_char = r_upper ? CH_UX : CH_LX;
            end
            S_LPAD: begin
                w_load = !r_out_valid || i_out_ready;
                w_char = r_zp ? CH_ZERO : CH_SPACE;
            end
            S_SIGN: begin
                w_load = !r_out_valid || i_out_ready;
                w_char = r_neg ? CH_MINUS : CH_PLUS;
            end
            S_DIG: begin
                w_load = !r_out_valid || i_out_ready;
                w_char = digit_char(r_digits[DIGIT_BITS-1 -: 4], r_upper);
                w_last = (r_ndig == 5'd1) && !w_has_rpad;
            end
            S_RPAD: begin
                w_load = !r_out_valid || i_out_ready;
                w_char = CH_SPACE;
                w_last = (r_pad == 6'd1);
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Control registers: sequencer state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_char <= w_char;
            r_last     <= w_last;
        end
    end

    // Request fields, shared shift/add-3 unit, digit stripping and counters.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_upper <= (i_op == OP_HEXU);
                    r_neg   <= w_neg;
                    r_sign  <= !w_hex && (w_neg || i_show_sign);
                    r_pfx   <= w_hex && i_alt_prefix;
                    r_lj    <= i_left_justify;
                    r_zp    <= i_zero_pad;
                    r_width <= (i_field_width > WIDTH_LIMIT) ? WIDTH_LIMIT : i_field_width;
                    r_mag   <= w_mag;
                    r_bit   <= 6'd0;
                    r_digits <= w_hex ? {w_mag, {(DIGIT_BITS-64){1'b0}}} : '0;
                    r_ndig  <= w_hex ? 5'(NUM_HEX_DIGITS) : 5'(NUM_DEC_DIGITS);
                end
            end
            S_CONV: begin
                r_digits <= {w_adj[DIGIT_BITS-2:0], r_mag[63]};
                r_mag    <= {r_mag[62:0], 1'b0};
                r_bit    <= r_bit + 6'd1;
            end
            S_NORM: begin
                if (w_norm_done) begin
                    r_pad <= w_pad;
                end else begin
                    r_digits <= {r_digits[DIGIT_BITS-5:0], 4'd0};
                    r_ndig   <= r_ndig - 5'd1;
                end
            end
            S_LPAD, S_RPAD: begin
                if (w_load) begin
                    r_pad <= r_pad - 6'd1;
                end
            end
            S_DIG: begin
                if (w_load) begin
                    r_digits <= {r_digits[DIGIT_BITS-5:0], 4'd0};
                    r_ndig   <= r_ndig - 5'd1;
                end
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // The BCD register never holds a digit above nine while converting.
    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> w_bcd_ok)
        else $error("BCD digit out of range during conversion");

    // The digit and stripping phases always hold between one and twenty digits.
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG || r_state == S_NORM) |-> (r_ndig != 5'd0 && r_ndig <= 5'd20))
        else $error("digit count out of range");

    // An accepted request starts conversion or digit stripping next cycle.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV || r_state == S_NORM))
        else $error("request accepted without starting work");

    // The sequencer returns to idle only right after loading the final character.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |-> (w_load && w_last))
        else $error("request ended without a final character");
`endif

endmodule
